>>> rtl/core/ilb_pkg.sv
// indexed list buffer: shared payload types, action and status codes
// no dependencies; imported by the core sequencer and the top level
`timescale 1ns / 1ps

package ilb_pkg;

	// action codes
	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_POP    = 3'd1;
	localparam logic [2:0] ACT_GET    = 3'd2;
	localparam logic [2:0] ACT_INSERT = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// request transaction
	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  index;
		logic [31:0] value;
	} ilb_req_t;

	// response transaction
	typedef struct packed {
		logic [31:0] value_out;
		logic [1:0]  status;
		logic [6:0]  length_now;
		logic        is_empty;
	} ilb_rsp_t;

	// finished operation handed from the sequencer to the output stage
	typedef struct packed {
		logic     valid;
		ilb_rsp_t rsp;
	} ilb_done_t;

endpackage

>>> rtl/core/ilb_ram.sv
// indexed list buffer: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module ilb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/ilb_seq.sv
// indexed list buffer: operation sequencer, owns the entry count and drives the entry ram
// depends on ilb_pkg and ilb_ram
`timescale 1ns / 1ps

module ilb_seq #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ilb_pkg::ilb_req_t item,
	output logic              idle,
	output ilb_pkg::ilb_done_t done,
	input  logic              done_ack
);

	import ilb_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_READ     = 3'd1;
	localparam logic [2:0] S_INS      = 3'd2;
	localparam logic [2:0] S_INS_LAST = 3'd3;
	localparam logic [2:0] S_REM_READ = 3'd4;
	localparam logic [2:0] S_REM      = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0]           state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [AW-1:0]        ptr_q, ptr_d;
	logic [5:0]           idx_q, idx_d;
	logic [WORD_BITS-1:0] word_q, word_d;
	logic [31:0]          val_q, val_d;
	logic [1:0]           st_q, st_d;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;

	logic [CMPW-1:0]           cnt_ext, idx_in_ext, idx_ext, ptr_ext;
	logic                      full, empty;
	logic [WORD_BITS+31:0]     word_wide;
	logic [WORD_BITS+31:0]     rd_wide;
	logic [WORD_BITS-1:0]      word_in;
	logic [31:0]               rd_word;

	// entry storage
	ilb_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// width adaptation between the 32-bit payload and the stored word
	assign word_wide = {{WORD_BITS{1'b0}}, item.value};
	assign word_in   = word_wide[WORD_BITS-1:0];
	assign rd_wide   = {32'd0, rdata};
	assign rd_word   = rd_wide[31:0];

	assign cnt_ext    = CMPW'(cnt_q);
	assign idx_in_ext = CMPW'(item.index);
	assign idx_ext    = CMPW'(idx_q);
	assign ptr_ext    = CMPW'(ptr_q);
	assign full       = (cnt_ext == CMPW'(DEPTH));
	assign empty      = (cnt_q == '0);

	// next-state and ram access decode
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ptr_d   = ptr_q;
		idx_d   = idx_q;
		word_d  = word_q;
		val_d   = val_q;
		st_d    = st_q;
		we      = 1'b0;
		waddr   = ptr_q;
		wdata   = rdata;
		raddr   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					idx_d   = item.index;
					word_d  = word_in;
					val_d   = '0;
					st_d    = ST_OK;
					state_d = S_DONE;
					unique case (item.action)
						ACT_PUSH, ACT_INSERT: begin
							if (full) begin
								st_d = ST_FULL;
							end else if (item.action == ACT_PUSH || idx_in_ext >= cnt_ext) begin
								we    = 1'b1;
								waddr = AW'(cnt_q);
								wdata = word_in;
								cnt_d = cnt_q + CW'(1);
							end else begin
								// open a gap at index: move entries up from the tail
								ptr_d   = AW'(cnt_q);
								raddr   = AW'(cnt_q - CW'(1));
								state_d = S_INS;
							end
						end
						ACT_POP, ACT_REMOVE: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else if (item.action == ACT_POP || idx_in_ext >= cnt_ext) begin
								raddr   = AW'(cnt_q - CW'(1));
								cnt_d   = cnt_q - CW'(1);
								state_d = S_READ;
							end else begin
								raddr   = AW'(idx_in_ext);
								state_d = S_REM_READ;
							end
						end
						ACT_GET: begin
							if (idx_in_ext < cnt_ext) begin
								raddr   = AW'(idx_in_ext);
								state_d = S_READ;
							end else begin
								st_d = ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				val_d   = rd_word;
				state_d = S_DONE;
			end
			S_INS: begin
				// write the word read last cycle one place up
				we    = 1'b1;
				waddr = ptr_q;
				wdata = rdata;
				if (ptr_ext == idx_ext + CMPW'(1)) begin
					state_d = S_INS_LAST;
				end else begin
					raddr = ptr_q - AW'(2);
					ptr_d = ptr_q - AW'(1);
				end
			end
			S_INS_LAST: begin
				we      = 1'b1;
				waddr   = AW'(idx_ext);
				wdata   = word_q;
				cnt_d   = cnt_q + CW'(1);
				state_d = S_DONE;
			end
			S_REM_READ: begin
				val_d = rd_word;
				if (idx_ext + CMPW'(1) == cnt_ext) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_DONE;
				end else begin
					raddr   = AW'(idx_ext + CMPW'(1));
					ptr_d   = AW'(idx_ext);
					state_d = S_REM;
				end
			end
			S_REM: begin
				// write the word read last cycle one place down
				we    = 1'b1;
				waddr = ptr_q;
				wdata = rdata;
				if (ptr_ext + CMPW'(2) == cnt_ext) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_DONE;
				end else begin
					raddr = AW'(ptr_ext + CMPW'(2));
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_DONE: begin
				if (done_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// operation operands and result
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		idx_q  <= idx_d;
		word_q <= word_d;
		val_q  <= val_d;
		st_q   <= st_d;
	end

	assign idle                = (state_q == S_IDLE);
	assign done.valid          = (state_q == S_DONE);
	assign done.rsp.value_out  = val_q;
	assign done.rsp.status     = st_q;
	assign done.rsp.length_now = cnt_ext[6:0];
	assign done.rsp.is_empty   = empty;

endmodule

>>> rtl/core/indexed_list_buffer_core.sv
// indexed list buffer: top level with request/response handshakes and the response register
// depends on ilb_pkg and ilb_seq
`timescale 1ns / 1ps

// Ordered list of up to DEPTH words held in one synchronous ram.
// Requests (req_valid/req_ready, payload req) carry push, pop, get, insert at
// index and remove at index; each request yields exactly one response
// (rsp_valid/rsp_ready, payload rsp) with the word read, a status, the length
// after the operation and an empty flag.
// One request is worked at a time; req_ready is high while the sequencer idles.
// Push, errors and unused actions finish straight from idle; pop and get pass
// through a read state; insert moves the entries from the tail down to index
// up one place, then writes the new word; remove reads the word at index,
// then moves the entries behind it down one place. Insert and remove take
// longer the further the index lies from the tail, since the ram moves one
// entry per cycle through its single write port while a gap is opened or closed.
// The response register holds a finished response while rsp_ready is low and
// the next request is still taken; its result waits in the sequencer until
// the register frees, and req_ready stays low meanwhile.
// Reset empties the list and clears both valids; ram contents are not cleared,
// entries past the length are never read.
module indexed_list_buffer_core #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ilb_pkg::ilb_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ilb_pkg::ilb_rsp_t rsp
);

	import ilb_pkg::*;

	logic      seq_idle;
	logic      start;
	logic      done_ack;
	ilb_done_t done;
	logic      rsp_valid_q;
	ilb_rsp_t  rsp_q;

	assign req_ready = seq_idle;
	assign start     = req_valid && seq_idle;

	// operation sequencer with the entry ram
	ilb_seq #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (req),
		.idle     (seq_idle),
		.done     (done),
		.done_ack (done_ack)
	);

	// response register takes a result when empty or being drained
	assign done_ack = done.valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_ack) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_ack) begin
			rsp_q <= done.rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the sequencer leaves idle after every accepted transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while an operation was in flight");

	// a failed operation returns zero; word-less ones also do, but are not checked here
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.value_out == '0)
		else $error("nonzero word with an error status");

	// empty flag agrees with the reported length
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.length_now == 7'd0)
		else $error("empty flag set with a nonzero length");

	// a refused push or insert reports a full list
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.length_now == 7'(DEPTH))
		else $error("full status with a length below capacity");

endmodule
